// ===== hw/rtl/svg_pkg.sv =====
// Shared types and constants for the state vector gate engine.
// Depends on nothing; imported by the controller, datapath and top level.
`default_nettype none

package svg_pkg;

    typedef enum logic [3:0] {
        OP_WRITE   = 4'd0,
        OP_READ    = 4'd1,
        OP_RESET   = 4'd2,
        OP_H       = 4'd3,
        OP_X       = 4'd4,
        OP_Y       = 4'd5,
        OP_Z       = 4'd6,
        OP_PHASE   = 4'd7,
        OP_RX      = 4'd8,
        OP_RY      = 4'd9,
        OP_CNOT    = 4'd10,
        OP_CPHASE  = 4'd11,
        OP_SWAP    = 4'd12,
        OP_TOFFOLI = 4'd13,
        OP_NEGATE  = 4'd14,
        OP_NONE    = 4'd15
    } t_op;

    localparam logic [1:0] STAT_DONE      = 2'd0;
    localparam logic [1:0] STAT_BAD_QUBIT = 2'd1;
    localparam logic [1:0] STAT_BAD_INDEX = 2'd2;

    typedef enum logic [2:0] {
        WS_ZERO,
        WS_ONE,
        WS_INPUT,
        WS_RES0,
        WS_RES1
    } t_wsel;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WRITE,
        S_READ,
        S_TRIG_S,
        S_TRIG_C,
        S_SCAN,
        S_MUL,
        S_WR0,
        S_WR1,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        CF_ZERO,
        CF_ONE,
        CF_NEG_ONE,
        CF_H,
        CF_NEG_H,
        CF_C,
        CF_S,
        CF_NEG_S
    } t_coef;

    typedef enum logic [1:0] {
        SEL_X0,
        SEL_Y0,
        SEL_X1,
        SEL_Y1
    } t_opnd;

    typedef struct packed {
        t_coef coef;
        t_opnd sel;
    } t_term;

    typedef struct packed {
        logic       latch;
        logic       rd_en;
        logic       mul_en;
        logic [3:0] step;
        logic       trig_s;
        logic       trig_c;
        logic       we;
        t_wsel      wsel;
        t_op        op;
    } t_cmd;

    localparam int FRAC_BITS = 14;
    localparam int MUL_STEPS = 8;
    localparam logic signed [16:0] UNIT   = 17'sd16384;
    localparam logic signed [16:0] H_COEF = 17'sd11585;

    localparam logic [14:0] QSIN [0:16] = '{
        15'd0,     15'd1606,  15'd3196,  15'd4756,  15'd6270,  15'd7723,
        15'd9102,  15'd10394, 15'd11585, 15'd12665, 15'd13623, 15'd14449,
        15'd15137, 15'd15679, 15'd16069, 15'd16305, 15'd16384
    };

endpackage

`default_nettype wire

// ===== hw/rtl/svg_dp.sv =====
// Datapath: amplitude memory, sine unit, multiply-accumulate and rounding.
// Depends on svg_pkg; driven by commands from svg_ctrl.
`default_nettype none

module svg_dp
    import svg_pkg::*;
#(
    parameter int AMP_WIDTH = 16,
    parameter int AW        = 10
) (
    input  wire logic                        i_clk,
    input  wire t_cmd                        i_cmd,
    input  wire logic [AW-1:0]               i_rd_addr0,
    input  wire logic [AW-1:0]               i_rd_addr1,
    input  wire logic [AW-1:0]               i_wr_addr,
    input  wire logic [15:0]                 i_angle,
    input  wire logic signed [15:0]          i_in_re,
    input  wire logic signed [15:0]          i_in_im,
    output logic signed [AMP_WIDTH-1:0]      o_rd_re,
    output logic signed [AMP_WIDTH-1:0]      o_rd_im
);

    localparam int DEPTH  = 1 << AW;
    localparam int PROD_W = AMP_WIDTH + 17;
    localparam int ACC_W  = AMP_WIDTH + 18;
    localparam logic signed [ACC_W-1:0] AMP_MAX =
        ACC_W'((64'sd1 <<< (AMP_WIDTH - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] AMP_MIN = -AMP_MAX - ACC_W'(1);

    logic [2*AMP_WIDTH-1:0] mem [0:DEPTH-1];
    logic [2*AMP_WIDTH-1:0] r_rd0, r_rd1;
    logic [15:0]            r_angle;
    logic signed [15:0]     r_in_re, r_in_im;
    logic signed [16:0]     r_sin, r_cos;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [AMP_WIDTH-1:0] r_res [0:3];

    logic [16:0]              phase;
    logic signed [16:0]       sine;
    t_term                    term;
    logic signed [16:0]       coef;
    logic signed [AMP_WIDTH-1:0] opnd;
    logic [2:0]               prev;
    logic signed [ACC_W-1:0]  sum;
    logic [2*AMP_WIDTH-1:0]   wdata;

    function automatic logic signed [AMP_WIDTH-1:0] sat_amp(
        input logic signed [ACC_W-1:0] v
    );
        if (v > AMP_MAX) begin
            return AMP_MAX[AMP_WIDTH-1:0];
        end else if (v < AMP_MIN) begin
            return AMP_MIN[AMP_WIDTH-1:0];
        end
        return v[AMP_WIDTH-1:0];
    endfunction

    // Round half up by an arithmetic shift after adding half an LSB.
    function automatic logic signed [AMP_WIDTH-1:0] rnd(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        t = v + ACC_W'(1 << (FRAC_BITS - 1));
        return sat_amp(t >>> FRAC_BITS);
    endfunction

    // Quarter-wave table with linear interpolation over 2^-17 turn units.
    function automatic logic signed [16:0] sin17(input logic [16:0] p);
        logic [15:0] r;
        logic [4:0]  i;
        logic [10:0] f;
        logic [14:0] base;
        logic [14:0] diff;
        logic [25:0] prod;
        logic [15:0] v;
        r = p[15] ? (16'd32768 - {1'b0, p[14:0]}) : {1'b0, p[14:0]};
        i = r[15:11];
        f = r[10:0];
        if (i >= 5'd16) begin
            v = 16'd16384;
        end else begin
            base = QSIN[i];
            diff = QSIN[i + 5'd1] - base;
            prod = 26'(diff) * 26'(f) + 26'd1024;
            v = 16'(base) + 16'(prod >> 11);
        end
        return p[16] ? -$signed({1'b0, v}) : $signed({1'b0, v});
    endfunction

    function automatic t_term pick(input t_op op, input logic [2:0] s);
        t_term tm;
        tm.coef = CF_ZERO;
        tm.sel  = SEL_X0;
        case (op)
            OP_H: begin
                tm.coef = (s[2] && s[0]) ? CF_NEG_H : CF_H;
                tm.sel  = s[0] ? (s[1] ? SEL_Y1 : SEL_X1) : (s[1] ? SEL_Y0 : SEL_X0);
            end
            OP_X, OP_CNOT, OP_SWAP, OP_TOFFOLI: begin
                tm.coef = s[0] ? CF_ZERO : CF_ONE;
                tm.sel  = s[2] ? (s[1] ? SEL_Y0 : SEL_X0) : (s[1] ? SEL_Y1 : SEL_X1);
            end
            OP_Y: begin
                case (s)
                    3'd0:    tm = '{CF_ONE, SEL_Y1};
                    3'd2:    tm = '{CF_NEG_ONE, SEL_X1};
                    3'd4:    tm = '{CF_NEG_ONE, SEL_Y0};
                    3'd6:    tm = '{CF_ONE, SEL_X0};
                    default: tm = '{CF_ZERO, SEL_X0};
                endcase
            end
            OP_Z, OP_NEGATE: begin
                tm.coef = (s[2] && !s[0]) ? CF_NEG_ONE : CF_ZERO;
                tm.sel  = s[1] ? SEL_Y1 : SEL_X1;
            end
            OP_PHASE, OP_CPHASE: begin
                case (s)
                    3'd4:    tm = '{CF_C, SEL_X1};
                    3'd5:    tm = '{CF_NEG_S, SEL_Y1};
                    3'd6:    tm = '{CF_S, SEL_X1};
                    3'd7:    tm = '{CF_C, SEL_Y1};
                    default: tm = '{CF_ZERO, SEL_X0};
                endcase
            end
            OP_RX: begin
                case (s)
                    3'd0:    tm = '{CF_C, SEL_X0};
                    3'd1:    tm = '{CF_S, SEL_Y1};
                    3'd2:    tm = '{CF_C, SEL_Y0};
                    3'd3:    tm = '{CF_NEG_S, SEL_X1};
                    3'd4:    tm = '{CF_C, SEL_X1};
                    3'd5:    tm = '{CF_S, SEL_Y0};
                    3'd6:    tm = '{CF_C, SEL_Y1};
                    default: tm = '{CF_NEG_S, SEL_X0};
                endcase
            end
            OP_RY: begin
                case (s)
                    3'd0:    tm = '{CF_C, SEL_X0};
                    3'd1:    tm = '{CF_NEG_S, SEL_X1};
                    3'd2:    tm = '{CF_C, SEL_Y0};
                    3'd3:    tm = '{CF_NEG_S, SEL_Y1};
                    3'd4:    tm = '{CF_C, SEL_X1};
                    3'd5:    tm = '{CF_S, SEL_X0};
                    3'd6:    tm = '{CF_C, SEL_Y1};
                    default: tm = '{CF_S, SEL_Y0};
                endcase
            end
            default: tm = '{CF_ZERO, SEL_X0};
        endcase
        return tm;
    endfunction

    // Phase gates use the full angle; rotations use the half angle.
    always_comb begin
        if (i_cmd.op == OP_PHASE || i_cmd.op == OP_CPHASE) begin
            phase = {r_angle, 1'b0};
        end else begin
            phase = {1'b0, r_angle};
        end
        sine = sin17(i_cmd.trig_c ? (phase + 17'h08000) : phase);
    end

    always_comb begin
        term = pick(i_cmd.op, i_cmd.step[2:0]);
        case (term.coef)
            CF_ONE:     coef = UNIT;
            CF_NEG_ONE: coef = -UNIT;
            CF_H:       coef = H_COEF;
            CF_NEG_H:   coef = -H_COEF;
            CF_C:       coef = r_cos;
            CF_S:       coef = r_sin;
            CF_NEG_S:   coef = -r_sin;
            default:    coef = '0;
        endcase
        case (term.sel)
            SEL_X0:  opnd = r_rd0[2*AMP_WIDTH-1:AMP_WIDTH];
            SEL_Y0:  opnd = r_rd0[AMP_WIDTH-1:0];
            SEL_X1:  opnd = r_rd1[2*AMP_WIDTH-1:AMP_WIDTH];
            default: opnd = r_rd1[AMP_WIDTH-1:0];
        endcase
        prev = 3'(i_cmd.step - 4'd1);
        sum  = r_acc + ACC_W'(r_prod);
    end

    always_comb begin
        case (i_cmd.wsel)
            WS_ONE:   wdata = {sat_amp(ACC_W'(UNIT)), {AMP_WIDTH{1'b0}}};
            WS_INPUT: wdata = {sat_amp(ACC_W'(r_in_re)), sat_amp(ACC_W'(r_in_im))};
            WS_RES0:  wdata = {r_res[0], r_res[1]};
            WS_RES1:  wdata = {r_res[2], r_res[3]};
            default:  wdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            mem[i_wr_addr] <= wdata;
        end
        if (i_cmd.rd_en) begin
            r_rd0 <= mem[i_rd_addr0];
            r_rd1 <= mem[i_rd_addr1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_angle <= i_angle;
            r_in_re <= i_in_re;
            r_in_im <= i_in_im;
        end
        if (i_cmd.trig_s) begin
            r_sin <= sine;
        end
        if (i_cmd.trig_c) begin
            r_cos <= sine;
        end
        // Product of one step is summed in the following step.
        if (i_cmd.mul_en) begin
            if (i_cmd.step < 4'(MUL_STEPS)) begin
                r_prod <= PROD_W'(coef) * PROD_W'(opnd);
            end
            if (i_cmd.step != 4'd0) begin
                if (!prev[0]) begin
                    r_acc <= ACC_W'(r_prod);
                end else begin
                    r_res[prev[2:1]] <= rnd(sum);
                end
            end
        end
    end

    assign o_rd_re = r_rd0[2*AMP_WIDTH-1:AMP_WIDTH];
    assign o_rd_im = r_rd0[AMP_WIDTH-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/svg_ctrl.sv =====
// Controller: operation decode, qubit checks, index sweep and sequencing.
// Depends on svg_pkg; issues commands to svg_dp.
`default_nettype none

module svg_ctrl
    import svg_pkg::*;
#(
    parameter int QUBIT_LIMIT = 10
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [3:0]            i_op,
    input  wire logic [3:0]            i_qubit_a,
    input  wire logic [3:0]            i_qubit_b,
    input  wire logic [3:0]            i_qubit_c,
    input  wire logic [9:0]            i_index,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [3:0]            i_cfg_data,
    output t_cmd                       o_cmd,
    output logic [QUBIT_LIMIT-1:0]     o_rd_addr0,
    output logic [QUBIT_LIMIT-1:0]     o_rd_addr1,
    output logic [QUBIT_LIMIT-1:0]     o_wr_addr,
    output logic                       o_result_valid,
    output logic                       o_is_read,
    output logic [9:0]                 o_out_index,
    output logic [1:0]                 o_status
);

    localparam int AW = QUBIT_LIMIT;
    localparam int NW = $clog2(QUBIT_LIMIT + 1);

    t_state        r_state, n_state;
    logic [AW-1:0] r_j, n_j;
    logic [3:0]    r_step, n_step;
    t_op           r_op, n_op;
    logic [AW-1:0] r_must1, n_must1, r_must0, n_must0, r_flip, n_flip;
    logic [AW-1:0] r_last, n_last;
    logic          r_wr_a0, n_wr_a0;
    logic [1:0]    r_status, n_status;
    logic [9:0]    r_oidx, n_oidx;
    logic          r_is_read, n_is_read;
    logic          r_report, n_report;
    logic [3:0]    r_cfg;

    logic [NW-1:0] n_eff;
    logic [AW:0]   size;
    logic          qa_bad, qb_bad, qc_bad, idx_bad, accept, sel_j;
    logic [AW-1:0] ma, mb, mc, idx_addr, last_all;
    t_op           in_op;

    always_comb begin
        if (r_cfg == 4'd0) begin
            n_eff = NW'(1);
        end else if (32'(r_cfg) > QUBIT_LIMIT) begin
            n_eff = NW'(QUBIT_LIMIT);
        end else begin
            n_eff = NW'(r_cfg);
        end
        size     = (AW+1)'(1) << n_eff;
        last_all = AW'(size - (AW+1)'(1));
        qa_bad   = 32'(i_qubit_a) >= 32'(n_eff);
        qb_bad   = 32'(i_qubit_b) >= 32'(n_eff);
        qc_bad   = 32'(i_qubit_c) >= 32'(n_eff);
        idx_bad  = 32'(i_index) >= 32'(size);
        ma       = AW'(1) << i_qubit_a;
        mb       = AW'(1) << i_qubit_b;
        mc       = AW'(1) << i_qubit_c;
        idx_addr = AW'(i_index);
        in_op    = t_op'(i_op);
        accept   = (r_state == S_IDLE) && start;
        // An index takes part when its required bits are set and cleared.
        sel_j    = ((r_j & r_must1) == r_must1) && ((r_j & r_must0) == '0);
    end

    always_comb begin
        n_state   = r_state;
        n_j       = r_j;
        n_step    = r_step;
        n_op      = r_op;
        n_must1   = r_must1;
        n_must0   = r_must0;
        n_flip    = r_flip;
        n_last    = r_last;
        n_wr_a0   = r_wr_a0;
        n_status  = r_status;
        n_oidx    = r_oidx;
        n_is_read = r_is_read;
        n_report  = r_report;
        case (r_state)
            S_CLEAR: begin
                n_j = r_j + AW'(1);
                if (r_j == '1) begin
                    n_state = r_report ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_op      = in_op;
                    n_status  = STAT_DONE;
                    n_oidx    = '0;
                    n_is_read = 1'b0;
                    n_j       = '0;
                    n_last    = last_all;
                    n_must1   = '0;
                    n_must0   = ma;
                    n_flip    = ma;
                    n_wr_a0   = 1'b1;
                    n_step    = '0;
                    n_state   = S_DONE;
                    case (in_op)
                        OP_WRITE, OP_READ, OP_NEGATE: begin
                            n_oidx = i_index;
                            if (idx_bad) begin
                                n_status = STAT_BAD_INDEX;
                            end else begin
                                n_j = idx_addr;
                                if (in_op == OP_WRITE) begin
                                    n_state = S_WRITE;
                                end else if (in_op == OP_READ) begin
                                    n_is_read = 1'b1;
                                    n_state   = S_READ;
                                end else begin
                                    n_last  = idx_addr;
                                    n_must0 = '0;
                                    n_flip  = '0;
                                    n_wr_a0 = 1'b0;
                                    n_state = S_SCAN;
                                end
                            end
                        end
                        OP_RESET: begin
                            n_report = 1'b1;
                            n_state  = S_CLEAR;
                        end
                        OP_H, OP_X, OP_Y, OP_Z, OP_PHASE, OP_RX, OP_RY: begin
                            if (qa_bad) begin
                                n_status = STAT_BAD_QUBIT;
                            end else begin
                                n_wr_a0 = !(in_op == OP_Z || in_op == OP_PHASE);
                                if (in_op == OP_PHASE || in_op == OP_RX || in_op == OP_RY) begin
                                    n_state = S_TRIG_S;
                                end else begin
                                    n_state = S_SCAN;
                                end
                            end
                        end
                        OP_CNOT, OP_CPHASE, OP_SWAP: begin
                            if (qa_bad || qb_bad || i_qubit_a == i_qubit_b) begin
                                n_status = STAT_BAD_QUBIT;
                            end else if (in_op == OP_CPHASE) begin
                                n_must1 = ma | mb;
                                n_must0 = '0;
                                n_flip  = '0;
                                n_wr_a0 = 1'b0;
                                n_state = S_TRIG_S;
                            end else begin
                                n_must1 = ma;
                                n_must0 = mb;
                                n_flip  = (in_op == OP_SWAP) ? (ma | mb) : mb;
                                n_state = S_SCAN;
                            end
                        end
                        OP_TOFFOLI: begin
                            if (qa_bad || qb_bad || qc_bad || i_qubit_a == i_qubit_b
                                || i_qubit_a == i_qubit_c || i_qubit_b == i_qubit_c) begin
                                n_status = STAT_BAD_QUBIT;
                            end else begin
                                n_must1 = ma | mb;
                                n_must0 = mc;
                                n_flip  = mc;
                                n_state = S_SCAN;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_WRITE:  n_state = S_DONE;
            S_READ:   n_state = S_DONE;
            S_TRIG_S: n_state = S_TRIG_C;
            S_TRIG_C: n_state = S_SCAN;
            S_SCAN: begin
                if (sel_j) begin
                    n_step  = '0;
                    n_state = S_MUL;
                end else if (r_j == r_last) begin
                    n_state = S_DONE;
                end else begin
                    n_j = r_j + AW'(1);
                end
            end
            S_MUL: begin
                n_step = r_step + 4'd1;
                if (r_step == 4'(MUL_STEPS)) begin
                    n_state = r_wr_a0 ? S_WR0 : S_WR1;
                end
            end
            S_WR0: n_state = S_WR1;
            S_WR1: begin
                if (r_j == r_last) begin
                    n_state = S_DONE;
                end else begin
                    n_j     = r_j + AW'(1);
                    n_state = S_SCAN;
                end
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.op       = r_op;
        o_cmd.step     = r_step;
        o_cmd.latch    = accept;
        o_rd_addr0     = r_j;
        o_rd_addr1     = r_j ^ r_flip;
        o_wr_addr      = r_j;
        busy           = (r_state != S_IDLE);
        o_cfg_ready    = (r_state == S_IDLE);
        o_result_valid = (r_state == S_DONE);
        case (r_state)
            S_CLEAR: begin
                o_cmd.we   = 1'b1;
                o_cmd.wsel = (r_j == '0) ? WS_ONE : WS_ZERO;
            end
            S_WRITE: begin
                o_cmd.we   = 1'b1;
                o_cmd.wsel = WS_INPUT;
            end
            S_READ:   o_cmd.rd_en  = 1'b1;
            S_TRIG_S: o_cmd.trig_s = 1'b1;
            S_TRIG_C: o_cmd.trig_c = 1'b1;
            S_SCAN:   o_cmd.rd_en  = sel_j;
            S_MUL:    o_cmd.mul_en = 1'b1;
            S_WR0: begin
                o_cmd.we   = 1'b1;
                o_cmd.wsel = WS_RES0;
            end
            S_WR1: begin
                o_cmd.we   = 1'b1;
                o_cmd.wsel = WS_RES1;
                o_wr_addr  = r_j ^ r_flip;
            end
            default: o_cmd.we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_j       <= '0;
            r_step    <= '0;
            r_op      <= OP_NONE;
            r_must1   <= '0;
            r_must0   <= '0;
            r_flip    <= '0;
            r_last    <= '0;
            r_wr_a0   <= 1'b0;
            r_status  <= STAT_DONE;
            r_oidx    <= '0;
            r_is_read <= 1'b0;
            r_report  <= 1'b0;
            r_cfg     <= 4'd10;
        end else begin
            r_state   <= n_state;
            r_j       <= n_j;
            r_step    <= n_step;
            r_op      <= n_op;
            r_must1   <= n_must1;
            r_must0   <= n_must0;
            r_flip    <= n_flip;
            r_last    <= n_last;
            r_wr_a0   <= n_wr_a0;
            r_status  <= n_status;
            r_oidx    <= n_oidx;
            r_is_read <= n_is_read;
            r_report  <= n_report;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg <= i_cfg_data;
            end
        end
    end

    assign o_is_read   = r_is_read;
    assign o_out_index = r_oidx;
    assign o_status    = r_status;

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held longer than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted item did not make the block busy");

    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.we |-> busy)
        else $error("memory written while idle");

    a_read_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && r_is_read) |-> (r_status == STAT_DONE))
        else $error("read flagged with a failing status");

endmodule

`default_nettype wire

// ===== hw/rtl/state_vector_gate_engine.sv =====
// Top level of the state vector gate engine: controller plus datapath.
// Depends on svg_pkg, svg_ctrl and svg_dp.
// A gate sweeps the indices and rewrites each selected pair (one entry for Z,
// phase and controlled phase), after the sine unit runs if an angle is used.
// One item at a time; the next is accepted the cycle after the result strobe.
// After reset, and for a vector reset item, a clearing pass writes all
// 2^QUBIT_LIMIT store entries while busy is high. Results cannot be stalled.
`default_nettype none

module state_vector_gate_engine
    import svg_pkg::*;
#(
    parameter int QUBIT_LIMIT = 10,
    parameter int AMP_WIDTH   = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [3:0]         i_op,
    input  wire logic [3:0]         i_qubit_a,
    input  wire logic [3:0]         i_qubit_b,
    input  wire logic [3:0]         i_qubit_c,
    input  wire logic [15:0]        i_angle,
    input  wire logic [9:0]         i_index,
    input  wire logic signed [15:0] i_in_re,
    input  wire logic signed [15:0] i_in_im,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [3:0]         i_cfg_data,
    output logic                    o_result_valid,
    output logic signed [15:0]      o_out_re,
    output logic signed [15:0]      o_out_im,
    output logic [9:0]              o_out_index,
    output logic [1:0]              o_status
);

    t_cmd                        cmd;
    logic [QUBIT_LIMIT-1:0]      rd_addr0, rd_addr1, wr_addr;
    logic signed [AMP_WIDTH-1:0] rd_re, rd_im;
    logic                        is_read;

    svg_ctrl #(
        .QUBIT_LIMIT(QUBIT_LIMIT)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_qubit_a     (i_qubit_a),
        .i_qubit_b     (i_qubit_b),
        .i_qubit_c     (i_qubit_c),
        .i_index       (i_index),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_cmd         (cmd),
        .o_rd_addr0    (rd_addr0),
        .o_rd_addr1    (rd_addr1),
        .o_wr_addr     (wr_addr),
        .o_result_valid(o_result_valid),
        .o_is_read     (is_read),
        .o_out_index   (o_out_index),
        .o_status      (o_status)
    );

    svg_dp #(
        .AMP_WIDTH(AMP_WIDTH),
        .AW       (QUBIT_LIMIT)
    ) u_dp (
        .i_clk     (i_clk),
        .i_cmd     (cmd),
        .i_rd_addr0(rd_addr0),
        .i_rd_addr1(rd_addr1),
        .i_wr_addr (wr_addr),
        .i_angle   (i_angle),
        .i_in_re   (i_in_re),
        .i_in_im   (i_in_im),
        .o_rd_re   (rd_re),
        .o_rd_im   (rd_im)
    );

    // Only a successful read reports an amplitude.
    assign o_out_re = is_read ? 16'(rd_re) : '0;
    assign o_out_im = is_read ? 16'(rd_im) : '0;

endmodule

`default_nettype wire
